[rtl/core/sftm_pkg.sv]
// shared constants for the sensor frame trimmed mean core
// no dependencies; imported by every module in rtl/core
package sftm_pkg;

  localparam int BYTE_W          = 8;
  localparam int VALUE_W         = 16;
  localparam int SAMPLES_DEFAULT = 5;

  localparam logic [BYTE_W-1:0]  HDR_BYTE          = 8'h53;
  localparam logic [BYTE_W-1:0]  TRL_BYTE          = 8'h59;
  localparam logic [VALUE_W-1:0] ZERO_OFFSET_RESET = 16'd100;

endpackage

[rtl/core/sftm_parser.sv]
// frame parser and running sum, minimum and maximum of good frame values
// depends on sftm_pkg
module sftm_parser
  import sftm_pkg::*;
#(
  parameter int SAMPLES = SAMPLES_DEFAULT,
  parameter int SUM_W   = $clog2(SAMPLES * 65535 + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_ready,
  input  logic [BYTE_W-1:0]  byte_data,
  input  logic [VALUE_W-1:0] zero_offset,
  output logic               trim_valid,
  input  logic               trim_ready,
  output logic [SUM_W-1:0]   trim_sum
);

  localparam int CNT_W = $clog2(SAMPLES);

  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_DATA  = 2'd1,
    PH_TRAIL = 2'd2
  } phase_t;

  phase_t             phase;
  logic [1:0]         byte_index;
  logic [BYTE_W-1:0]  low_data;
  logic [BYTE_W-1:0]  high_data;
  logic [CNT_W-1:0]   sample_count;
  logic [SUM_W-1:0]   running_sum;
  logic [VALUE_W-1:0] running_min;
  logic [VALUE_W-1:0] running_max;

  logic               take;
  logic               emit;
  logic [VALUE_W-1:0] raw;
  logic [VALUE_W-1:0] val;
  logic [SUM_W-1:0]   sum_next;
  logic [VALUE_W-1:0] min_next;
  logic [VALUE_W-1:0] max_next;
  logic [SUM_W-1:0]   trim_calc;
  logic               last_sample;

  assign byte_ready = !trim_valid || trim_ready;
  assign take       = byte_valid && byte_ready;
  assign emit       = take && (phase == PH_TRAIL) && (byte_data == TRL_BYTE) && last_sample;

  always_comb begin
    raw         = {high_data, low_data};
    val         = (raw > zero_offset) ? (raw - zero_offset) : '0;
    sum_next    = running_sum + SUM_W'(val);
    min_next    = (val < running_min) ? val : running_min;
    max_next    = (val > running_max) ? val : running_max;
    trim_calc   = sum_next - SUM_W'(min_next) - SUM_W'(max_next);
    last_sample = (sample_count == CNT_W'(SAMPLES - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      byte_index   <= '0;
      low_data     <= '0;
      high_data    <= '0;
      sample_count <= '0;
      running_sum  <= '0;
      running_min  <= '1;
      running_max  <= '0;
      trim_valid   <= 1'b0;
    end else begin
      if (emit) begin
        trim_valid <= 1'b1;
      end else if (trim_ready) begin
        trim_valid <= 1'b0;
      end
      if (take) begin
        case (phase)
          PH_DATA: begin
            case (byte_index)
              2'd0: begin
                low_data   <= byte_data;
                byte_index <= 2'd1;
              end
              2'd1: begin
                high_data  <= byte_data;
                byte_index <= 2'd2;
              end
              default: begin
                byte_index <= '0;
                phase      <= (byte_data == (low_data ^ high_data)) ? PH_TRAIL : PH_HUNT;
              end
            endcase
          end
          PH_TRAIL: begin
            phase      <= PH_HUNT;
            byte_index <= '0;
            if (byte_data == TRL_BYTE) begin
              if (last_sample) begin
                trim_sum     <= trim_calc;
                sample_count <= '0;
                running_sum  <= '0;
                running_min  <= '1;
                running_max  <= '0;
              end else begin
                sample_count <= sample_count + 1'b1;
                running_sum  <= sum_next;
                running_min  <= min_next;
                running_max  <= max_next;
              end
            end
          end
          default: begin
            phase      <= (byte_data == HDR_BYTE) ? PH_DATA : PH_HUNT;
            byte_index <= '0;
          end
        endcase
      end
    end
  end

endmodule

[rtl/core/sftm_divider.sv]
// divide the trimmed sum by SAMPLES-2 through a reciprocal multiply
// depends on sftm_pkg; product register then output register
module sftm_divider
  import sftm_pkg::*;
#(
  parameter int SAMPLES = SAMPLES_DEFAULT,
  parameter int SUM_W   = $clog2(SAMPLES * 65535 + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               trim_valid,
  output logic               trim_ready,
  input  logic [SUM_W-1:0]   trim_sum,
  output logic               mean_valid,
  input  logic               mean_ready,
  output logic [VALUE_W-1:0] mean
);

  localparam int              DIVISOR = SAMPLES - 2;
  localparam int              SHIFT   = SUM_W + $clog2(DIVISOR);
  localparam longint unsigned MULT    = ((64'd1 << SHIFT) + DIVISOR - 1) / DIVISOR;
  localparam int              MULT_W  = SUM_W + 2;
  localparam int              PROD_W  = SUM_W + MULT_W;

  localparam logic [MULT_W-1:0] MULT_C = MULT_W'(MULT);

  logic              prod_valid;
  logic [PROD_W-1:0] prod;
  logic              out_free;
  logic              prod_free;
  logic [PROD_W-1:0] quot;

  assign out_free   = !mean_valid || mean_ready;
  assign prod_free  = !prod_valid || out_free;
  assign trim_ready = prod_free;
  assign quot       = prod >> SHIFT;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      mean_valid <= 1'b0;
    end else begin
      if (prod_free) begin
        prod_valid <= trim_valid;
        if (trim_valid) begin
          prod <= PROD_W'(trim_sum) * PROD_W'(MULT_C);
        end
      end
      if (out_free) begin
        mean_valid <= prod_valid;
        if (prod_valid) begin
          mean <= quot[VALUE_W-1:0];
        end
      end
    end
  end

endmodule

[rtl/core/sensor_frame_trimmed_mean_core.sv]
// top level of the sensor frame trimmed mean core
// depends on sftm_pkg, sftm_parser and sftm_divider
//
// usage:
//   s_axis carries received serial bytes from the force sensor, one byte per
//   word. frames are 0x53, low, high, low^high, 0x59; a bad check or trailer
//   drops the frame and parsing resumes with a header hunt.
//   each good frame value (high:low minus zero_offset, floored at zero) is
//   accumulated; every SAMPLES good frames one word leaves on m_axis: the
//   sum less min and max, divided by SAMPLES-2, truncated.
//   cfg writes zero_offset (reset 100); write it only while idle.
// throughput: one byte per cycle while no trimmed sum is held up (see stall),
//   set by the combined parse and accumulate update.
// path: after the edge that accepts the trailer byte, a result passes the
//   trimmed sum register, multiply register and output register to m_axis.
// reset: parser hunts for a header, accumulation empty, no output pending.
// stall: up to three results queue behind a stalled m_axis; once the third
//   waits in the trimmed sum register, s_axis_tready drops until it moves on.
module sensor_frame_trimmed_mean_core
  import sftm_pkg::*;
#(
  parameter int SAMPLES = SAMPLES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // [7:0] rx_byte
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [15:0]        m_axis_tdata,   // [15:0] force_mean
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [VALUE_W-1:0] cfg_data
);

  localparam int SUM_W = $clog2(SAMPLES * 65535 + 1);

  logic [VALUE_W-1:0] zero_offset;
  logic               trim_valid;
  logic               trim_ready;
  logic [SUM_W-1:0]   trim_sum;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_offset <= ZERO_OFFSET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      zero_offset <= cfg_data;
    end
  end

  sftm_parser #(
    .SAMPLES (SAMPLES),
    .SUM_W   (SUM_W)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (s_axis_tvalid),
    .byte_ready  (s_axis_tready),
    .byte_data   (s_axis_tdata),
    .zero_offset (zero_offset),
    .trim_valid  (trim_valid),
    .trim_ready  (trim_ready),
    .trim_sum    (trim_sum)
  );

  sftm_divider #(
    .SAMPLES (SAMPLES),
    .SUM_W   (SUM_W)
  ) u_divider (
    .clk        (clk),
    .rst        (rst),
    .trim_valid (trim_valid),
    .trim_ready (trim_ready),
    .trim_sum   (trim_sum),
    .mean_valid (m_axis_tvalid),
    .mean_ready (m_axis_tready),
    .mean       (m_axis_tdata)
  );

  // input only backs up behind a waiting trimmed sum
  assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> trim_valid)
    else $error("input stalled with no trimmed sum pending");

  // a new trimmed sum only follows an accepted byte
  assert property (@(posedge clk) disable iff (rst)
    $rose(trim_valid) |-> $past(s_axis_tvalid && s_axis_tready))
    else $error("trimmed sum appeared without an accepted byte");

  // trimmed sum never exceeds the largest sum of SAMPLES-2 values
  assert property (@(posedge clk) disable iff (rst)
    trim_valid |-> (trim_sum <= SUM_W'((SAMPLES - 2) * 65535)))
    else $error("trimmed sum out of range");

  // zero_offset is never changed without a config write
  assert property (@(posedge clk) disable iff (rst)
    !$past(cfg_valid) && !$past(rst) |-> $stable(zero_offset))
    else $error("zero_offset changed without a write");

endmodule
